// ===== rtl/core/pfa_pkg.sv =====
package pfa_pkg;

    // Storage geometry. The index and size fields have fixed widths on the ports.
    localparam int NUM_BLOCKS = 8;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = 3;
    localparam int CNT_BITS   = 4;

    // Configuration port geometry.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    // Fit rules. The unused code behaves as first fit.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Operations carried by an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ALLOC  = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_LOADED = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [1:0]          RST_FIT_POLICY    = FIT_FIRST;
    localparam logic [CNT_BITS-1:0] RST_BLOCKS_IN_USE = 4'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/pfa_ifs.sv =====
interface pfa_item_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [pfa_pkg::IDX_BITS-1:0]   block_index;
    logic [pfa_pkg::SIZE_BITS-1:0]  size_value;

    modport source (output valid, op, block_index, size_value, input ready);
    modport sink   (input valid, op, block_index, size_value, output ready);
endinterface

interface pfa_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [pfa_pkg::IDX_BITS-1:0]   chosen_block;
    logic [pfa_pkg::SIZE_BITS-1:0]  size_before;
    logic [pfa_pkg::SIZE_BITS-1:0]  space_left;

    modport source (output valid, status, chosen_block, size_before, space_left,
                    input ready);
    modport sink   (input valid, status, chosen_block, size_before, space_left,
                    output ready);
endinterface

interface pfa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pfa_pkg::CFG_IDX_BITS-1:0]   index;
    logic [pfa_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/partition_fit_allocator_core.sv =====
// Sequencing: a load item passes through S_LOAD and S_DONE after acceptance; an allocate
// item passes through S_SCAN, which issues one read of the space memory per cycle over the
// searched partitions (at most eight, none with a search count of zero), then S_DONE, which
// holds the result until the output register is free. Throughput: one item at a time; the next
// item is taken as soon as the result is handed to the output register. Reset (synchronous,
// active low) clears all free space through per-entry valid bits at once, with no clearing pass.
module partition_fit_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfa_item_if.sink    i_item,
    pfa_res_if.source   o_res,
    pfa_cfg_if.sink     i_cfg
);

    // Free space memory: one synchronous read port with registered data and one
    // write port. An entry whose valid bit is clear reads as zero free space.
    logic [pfa_pkg::SIZE_BITS-1:0]  r_mem [pfa_pkg::NUM_BLOCKS];
    logic [pfa_pkg::NUM_BLOCKS-1:0] r_vld;
    logic [pfa_pkg::SIZE_BITS-1:0]  r_mem_q;
    logic                           r_vld_q;

    logic                           rd_en;
    logic [pfa_pkg::IDX_BITS-1:0]   rd_addr;
    logic                           wr_en;
    logic [pfa_pkg::IDX_BITS-1:0]   wr_addr;
    logic [pfa_pkg::SIZE_BITS-1:0]  wr_data;

    // Configuration registers.
    logic [1:0]                     r_fit_policy;
    logic [pfa_pkg::CNT_BITS-1:0]   r_blocks_in_use;
    logic [pfa_pkg::CNT_BITS-1:0]   search_lim;

    // Sequencer state.
    pfa_pkg::t_state                r_state, n_state;
    logic                           r_op, n_op;
    logic [pfa_pkg::SIZE_BITS-1:0]  r_req, n_req;
    logic [pfa_pkg::CNT_BITS-1:0]   r_issue, n_issue;
    logic                           r_cmp_pend, n_cmp_pend;
    logic [pfa_pkg::IDX_BITS-1:0]   r_cmp_idx, n_cmp_idx;
    logic                           r_found, n_found;
    logic [pfa_pkg::IDX_BITS-1:0]   r_sel_idx, n_sel_idx;
    logic [pfa_pkg::SIZE_BITS-1:0]  r_sel_space, n_sel_space;

    // Output register.
    logic                           r_out_valid, n_out_valid;
    logic [1:0]                     r_out_status, n_out_status;
    logic [pfa_pkg::IDX_BITS-1:0]   r_out_block, n_out_block;
    logic [pfa_pkg::SIZE_BITS-1:0]  r_out_before, n_out_before;
    logic [pfa_pkg::SIZE_BITS-1:0]  r_out_left, n_out_left;

    logic                           item_fire;
    logic                           out_free;
    logic [pfa_pkg::SIZE_BITS-1:0]  rd_space;
    logic                           fits;
    logic                           take;

    // Configuration writes are always taken. Unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy    <= pfa_pkg::RST_FIT_POLICY;
            r_blocks_in_use <= pfa_pkg::RST_BLOCKS_IN_USE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pfa_pkg::CFG_FIT_POLICY:    r_fit_policy    <= i_cfg.data[1:0];
                pfa_pkg::CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A search count above the number of partitions saturates.
    assign search_lim = (r_blocks_in_use > pfa_pkg::CNT_BITS'(pfa_pkg::NUM_BLOCKS))
                      ? pfa_pkg::CNT_BITS'(pfa_pkg::NUM_BLOCKS) : r_blocks_in_use;

    // Memory array and its registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_vld_q <= r_vld[rd_addr];
            end
        end
    end

    assign rd_space = r_vld_q ? r_mem_q : '0;

    // Fit test on the entry whose read data arrives in this cycle. A zero request
    // fits every searched partition. Best fit and worst fit let a later equal entry
    // replace the current pick, which sends ties to the highest index.
    assign fits = (rd_space >= r_req);

    always_comb begin
        case (r_fit_policy)
            pfa_pkg::FIT_BEST:  take = !r_found || (rd_space <= r_sel_space);
            pfa_pkg::FIT_WORST: take = !r_found || (rd_space >= r_sel_space);
            default:            take = !r_found;
        endcase
    end

    assign item_fire    = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_res.ready;
    assign i_item.ready = (r_state == pfa_pkg::S_IDLE);

    // Sequencer. A load item reads the old free space, then writes the new value.
    // An allocate item issues one read per cycle over the searched partitions,
    // judges each one as its data returns, and in the final state writes back the
    // reduced free space of the chosen partition, if one fits, while it fills the output register.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_req        = r_req;
        n_issue      = r_issue;
        n_cmp_pend   = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_found      = r_found;
        n_sel_idx    = r_sel_idx;
        n_sel_space  = r_sel_space;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_block  = r_out_block;
        n_out_before = r_out_before;
        n_out_left   = r_out_left;
        rd_en        = 1'b0;
        rd_addr      = r_issue[pfa_pkg::IDX_BITS-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_sel_idx;
        wr_data      = r_req;

        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (item_fire) begin
                    n_op      = i_item.op;
                    n_req     = i_item.size_value;
                    n_found   = 1'b0;
                    n_issue   = '0;
                    n_sel_idx = i_item.block_index;
                    if (i_item.op == pfa_pkg::OP_LOAD) begin
                        rd_en   = 1'b1;
                        rd_addr = i_item.block_index;
                        n_state = pfa_pkg::S_LOAD;
                    end else begin
                        n_state = pfa_pkg::S_SCAN;
                    end
                end
            end
            pfa_pkg::S_LOAD: begin
                n_sel_space = rd_space;
                n_state     = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_SCAN: begin
                if (r_issue < search_lim) begin
                    rd_en      = 1'b1;
                    n_cmp_pend = 1'b1;
                    n_cmp_idx  = r_issue[pfa_pkg::IDX_BITS-1:0];
                    n_issue    = r_issue + pfa_pkg::CNT_BITS'(1);
                end else if (!r_cmp_pend) begin
                    n_state = pfa_pkg::S_DONE;
                end
                if (r_cmp_pend && fits && take) begin
                    n_found     = 1'b1;
                    n_sel_idx   = r_cmp_idx;
                    n_sel_space = rd_space;
                end
            end
            pfa_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = pfa_pkg::S_IDLE;
                    if (r_op == pfa_pkg::OP_LOAD) begin
                        wr_en        = 1'b1;
                        wr_data      = r_req;
                        n_out_status = pfa_pkg::ST_LOADED;
                        n_out_block  = r_sel_idx;
                        n_out_before = r_sel_space;
                        n_out_left   = r_req;
                    end else if (r_found) begin
                        wr_en        = 1'b1;
                        wr_data      = r_sel_space - r_req;
                        n_out_status = pfa_pkg::ST_ALLOC;
                        n_out_block  = r_sel_idx;
                        n_out_before = r_sel_space;
                        n_out_left   = r_sel_space - r_req;
                    end else begin
                        n_out_status = pfa_pkg::ST_NOFIT;
                        n_out_block  = '0;
                        n_out_before = '0;
                        n_out_left   = '0;
                    end
                end
            end
            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfa_pkg::S_IDLE;
            r_cmp_pend  <= 1'b0;
            r_found     <= 1'b0;
            r_issue     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_pend  <= n_cmp_pend;
            r_found     <= n_found;
            r_issue     <= n_issue;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_req        <= n_req;
        r_cmp_idx    <= n_cmp_idx;
        r_sel_idx    <= n_sel_idx;
        r_sel_space  <= n_sel_space;
        r_out_status <= n_out_status;
        r_out_block  <= n_out_block;
        r_out_before <= n_out_before;
        r_out_left   <= n_out_left;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.chosen_block = r_out_block;
    assign o_res.size_before  = r_out_before;
    assign o_res.space_left   = r_out_left;

`ifndef NO_ASSERTIONS
    // A new result is only produced by the final state of the sequencer.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state) == pfa_pkg::S_DONE)
        else $error("result appeared without passing the final state");

    // A no-fit result carries all zero fields.
    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == pfa_pkg::ST_NOFIT) |->
        (o_res.chosen_block == '0 && o_res.size_before == '0 && o_res.space_left == '0))
        else $error("no-fit result with nonzero fields");

    // An allocation never grows a partition's free space.
    a_alloc_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == pfa_pkg::ST_ALLOC) |->
        (o_res.space_left <= o_res.size_before))
        else $error("allocation left more space than before");

    // The scan never runs past the searched partitions.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfa_pkg::S_SCAN) |-> (r_issue <= search_lim))
        else $error("scan index past search limit");

    // Read data is only judged during the scan.
    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_pend |-> (r_state == pfa_pkg::S_SCAN))
        else $error("compare pending outside the scan");
`endif

endmodule
